// ===== src/sawe_pkg.sv =====
// shared types, constants and helpers of the stop-and-wait endpoint
// no dependencies; used by sawe_step and stop_and_wait_endpoint_unit
package sawe_pkg;

	localparam int MAX_MSGS      = 16;
	localparam int MAX_LEN_BYTES = 1024;
	localparam int SLOT_W        = $clog2(MAX_MSGS);
	localparam int NS_W          = $clog2(MAX_MSGS + 1);
	localparam int LEN_W         = $clog2(MAX_LEN_BYTES);
	localparam int SEQ_W         = 32;
	localparam int TICK_W        = 16;
	localparam int MISS_W        = 8;
	localparam int CNT_W         = 5;
	localparam int RES_MAX       = 3;
	localparam int RES_W         = 2;

	typedef enum logic [2:0] {
		REQ_TICK        = 3'd0,
		REQ_RX_PING     = 3'd1,
		REQ_RX_REGULAR  = 3'd2,
		REQ_LOAD_LEN    = 3'd3,
		REQ_TOGGLE_DROP = 3'd4,
		REQ_TOGGLE_DOWN = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		SEND_NONE    = 2'd0,
		SEND_PING    = 2'd1,
		SEND_REGULAR = 2'd2
	} send_kind_t;

	typedef enum logic [1:0] {
		RXF_NONE   = 2'd0,
		RXF_NO_FIN = 2'd1,
		RXF_FIN    = 2'd2
	} rx_fin_t;

	typedef enum logic [1:0] {
		REG_MSG_COUNT     = 2'd0,
		REG_TIMEOUT       = 2'd1,
		REG_PING_INTERVAL = 2'd2,
		REG_DOWN_THRESH   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]  msg_count;
		logic [TICK_W-1:0] timeout_ticks;
		logic [TICK_W-1:0] ping_interval_ticks;
		logic [MISS_W-1:0] miss_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [SEQ_W-1:0]  rx_seq;
		logic [SEQ_W-1:0]  rx_ack;
		logic              rx_fin_flag;
		logic              rx_ack_flag;
		logic              rx_seq_flag;
		logic [LEN_W-1:0]  msg_len_bytes;
		logic [SLOT_W-1:0] load_slot;
	} item_t;

	typedef struct packed {
		send_kind_t        send_kind;
		logic              has_content;
		logic [SLOT_W-1:0] content_slot;
		logic [SEQ_W-1:0]  tx_seq;
		logic [SEQ_W-1:0]  tx_ack;
		logic              tx_fin;
	} result_t;

	typedef struct packed {
		logic [NS_W-1:0]   next_slot;
		logic [SEQ_W-1:0]  cur_seq;
		logic [SEQ_W-1:0]  cur_ack;
		logic              fin_state;
		logic              clear_to_send;
		logic              peer_is_up;
		logic              ping_on;
		logic              drop_regular;
		logic              node_is_down;
		logic              timer_running;
		logic [TICK_W-1:0] timer_ticks;
		logic [TICK_W-1:0] alarm_ticks;
		logic [MISS_W-1:0] missed_pings;
		rx_fin_t           last_rx_fin;
		logic              done_flag;
		logic [LEN_W-1:0]  sent_len;
	} state_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [LEN_W-1:0]  data;
	} tbl_wr_t;

	function automatic result_t mk_result(send_kind_t kind, logic has,
			logic [SLOT_W-1:0] slot, logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
			logic fin);
		result_t r;
		r.send_kind    = kind;
		r.has_content  = has;
		r.content_slot = has ? slot : '0;
		r.tx_seq       = seq;
		r.tx_ack       = ack;
		r.tx_fin       = fin;
		return r;
	endfunction

	function automatic logic [SEQ_W-1:0] len_to_bits(logic [LEN_W-1:0] len);
		return SEQ_W'({len, 3'b000});
	endfunction

endpackage

// ===== src/sawe_step.sv =====
// next-state and result logic for one item of the stop-and-wait endpoint
// depends on sawe_pkg
module sawe_step (
	input  sawe_pkg::state_t  st,
	input  sawe_pkg::cfg_t    cfg,
	input  sawe_pkg::item_t   item,
	input  logic [sawe_pkg::LEN_W-1:0] rd_len,
	output sawe_pkg::state_t  nxt,
	output sawe_pkg::result_t res [sawe_pkg::RES_MAX],
	output logic [sawe_pkg::RES_W-1:0] res_cnt,
	output sawe_pkg::tbl_wr_t tbl_wr
);

	sawe_pkg::state_t v;
	logic [sawe_pkg::RES_W-1:0] cnt;
	logic [sawe_pkg::NS_W-1:0] n;
	logic [sawe_pkg::NS_W-1:0] lslot_ext;
	logic [sawe_pkg::LEN_W-1:0] prev_len;
	logic [sawe_pkg::LEN_W-1:0] cur_len;
	logic is_load;
	logic closed;
	sawe_pkg::result_t r;

	always_comb begin
		v         = st;
		cnt       = '0;
		closed    = 1'b0;
		r         = '0;
		tbl_wr    = '0;
		for (int i = 0; i < sawe_pkg::RES_MAX; i++) begin
			res[i] = '0;
		end
		n = (cfg.msg_count > sawe_pkg::CNT_W'(sawe_pkg::MAX_MSGS)) ?
			sawe_pkg::NS_W'(sawe_pkg::MAX_MSGS) : sawe_pkg::NS_W'(cfg.msg_count);
		is_load   = (item.req_type == sawe_pkg::REQ_LOAD_LEN);
		lslot_ext = sawe_pkg::NS_W'(item.load_slot);
		// table contents seen after this item's load
		prev_len = (is_load && st.next_slot != '0 && lslot_ext == st.next_slot - 1'b1) ?
			item.msg_len_bytes : st.sent_len;
		cur_len  = (is_load && lslot_ext == st.next_slot) ? item.msg_len_bytes : rd_len;

		if (!st.done_flag) begin
			if (n != '0) begin
				v.ping_on = 1'b1;
			end
			if (n != '0 && st.next_slot < n) begin
				v.fin_state = 1'b0;
			end
			v.sent_len = prev_len;

			case (item.req_type)
				sawe_pkg::REQ_LOAD_LEN: begin
					tbl_wr.we   = 1'b1;
					tbl_wr.addr = item.load_slot;
					tbl_wr.data = item.msg_len_bytes;
				end
				sawe_pkg::REQ_TOGGLE_DROP: begin
					v.drop_regular = ~st.drop_regular;
				end
				sawe_pkg::REQ_TOGGLE_DOWN: begin
					v.node_is_down = ~st.node_is_down;
					if (v.node_is_down) begin
						v.timer_running = 1'b0;
					end
				end
				sawe_pkg::REQ_TICK: begin
					if (v.timer_running && v.timer_ticks != '1) begin
						v.timer_ticks = v.timer_ticks + 1'b1;
					end
					if (v.alarm_ticks != '1) begin
						v.alarm_ticks = v.alarm_ticks + 1'b1;
					end
					if (v.alarm_ticks >= cfg.ping_interval_ticks) begin
						v.alarm_ticks = '0;
						if (v.missed_pings != '1) begin
							v.missed_pings = v.missed_pings + 1'b1;
						end
						if (v.ping_on && !v.node_is_down) begin
							res[cnt] = sawe_pkg::mk_result(sawe_pkg::SEND_PING, 1'b0, '0, '0, '0,
								1'b0);
							cnt = cnt + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase

			// send phase
			if (v.peer_is_up && !v.node_is_down) begin
				if (v.clear_to_send && v.next_slot < n) begin
					if (v.next_slot == '0) begin
						v.cur_seq = sawe_pkg::SEQ_W'(1);
					end else begin
						v.cur_seq = v.cur_seq + sawe_pkg::len_to_bits(prev_len);
					end
					if (v.next_slot == n - 1'b1) begin
						v.fin_state = 1'b1;
					end
					if (cnt < sawe_pkg::RES_W'(sawe_pkg::RES_MAX)) begin
						res[cnt] = sawe_pkg::mk_result(sawe_pkg::SEND_REGULAR, 1'b1,
							v.next_slot[sawe_pkg::SLOT_W-1:0], v.cur_seq, v.cur_ack,
							v.fin_state);
						cnt = cnt + 1'b1;
					end
					v.timer_running = 1'b1;
					v.timer_ticks   = '0;
					v.sent_len      = cur_len;
					v.next_slot     = v.next_slot + 1'b1;
					v.clear_to_send = 1'b0;
				end
				if (v.missed_pings > cfg.miss_limit &&
						(!v.fin_state || v.last_rx_fin == sawe_pkg::RXF_NO_FIN)) begin
					v.peer_is_up = 1'b0;
				end
				if (v.timer_running && v.timer_ticks > cfg.timeout_ticks) begin
					if (v.next_slot <= n && v.next_slot != '0) begin
						r = sawe_pkg::mk_result(sawe_pkg::SEND_REGULAR, 1'b1,
							sawe_pkg::SLOT_W'(v.next_slot - 1'b1), v.cur_seq, v.cur_ack,
							v.fin_state);
					end else begin
						r = sawe_pkg::mk_result(sawe_pkg::SEND_REGULAR, 1'b0, '0, v.cur_seq,
							v.cur_ack, v.fin_state);
					end
					if (cnt < sawe_pkg::RES_W'(sawe_pkg::RES_MAX)) begin
						res[cnt] = r;
						cnt = cnt + 1'b1;
					end
					v.timer_running = 1'b1;
					v.timer_ticks   = '0;
				end
			end

			// received message
			if (item.req_type == sawe_pkg::REQ_RX_PING ||
					item.req_type == sawe_pkg::REQ_RX_REGULAR) begin
				v.last_rx_fin = (item.req_type == sawe_pkg::REQ_RX_REGULAR && item.rx_fin_flag) ?
					sawe_pkg::RXF_FIN : sawe_pkg::RXF_NO_FIN;
				if (!v.node_is_down && item.req_type == sawe_pkg::REQ_RX_PING) begin
					v.missed_pings = '0;
					v.peer_is_up   = 1'b1;
					if (!v.ping_on) begin
						v.ping_on   = 1'b1;
						v.fin_state = 1'b0;
					end
				end else if (!v.node_is_down && !v.drop_regular) begin
					if (item.rx_fin_flag) begin
						v.cur_ack = item.rx_seq + 1'b1;
						if (n == '0 || v.next_slot >= n) begin
							v.fin_state = 1'b1;
						end
						if (cnt < sawe_pkg::RES_W'(sawe_pkg::RES_MAX)) begin
							res[cnt] = sawe_pkg::mk_result(sawe_pkg::SEND_REGULAR, 1'b0, '0,
								item.rx_ack, v.cur_ack, v.fin_state);
							cnt = cnt + 1'b1;
						end
						v.timer_running = 1'b1;
						v.timer_ticks   = '0;
					end
					if (item.rx_ack_flag) begin
						if (!v.fin_state && n == '0) begin
							if (item.rx_ack == v.cur_seq) begin
								v.timer_running = 1'b0;
								v.clear_to_send = 1'b1;
								v.cur_ack       = '1;
							end
						end else if (n != '0 && v.next_slot != '0 &&
								item.rx_ack == v.cur_seq + sawe_pkg::len_to_bits(v.sent_len)) begin
							v.timer_running = 1'b0;
							v.clear_to_send = 1'b1;
							v.cur_ack       = '1;
						end else if (v.fin_state && item.rx_ack == v.cur_seq + 1'b1) begin
							v.cur_seq = v.cur_seq + 1'b1;
							v.cur_ack = item.rx_seq + 1'b1;
							if (cnt < sawe_pkg::RES_W'(sawe_pkg::RES_MAX)) begin
								res[cnt] = sawe_pkg::mk_result(sawe_pkg::SEND_REGULAR, 1'b0, '0,
									v.cur_seq, v.cur_ack, v.fin_state);
								cnt = cnt + 1'b1;
							end
							v.ping_on   = 1'b0;
							v.done_flag = 1'b1;
							closed      = 1'b1;
						end
					end
					if (!closed && !v.fin_state && item.rx_seq_flag) begin
						v.cur_ack = item.rx_seq + sawe_pkg::len_to_bits(item.msg_len_bytes);
						if (n <= v.next_slot && cnt < sawe_pkg::RES_W'(sawe_pkg::RES_MAX)) begin
							res[cnt] = sawe_pkg::mk_result(sawe_pkg::SEND_REGULAR, 1'b0, '0,
								v.cur_seq, v.cur_ack, v.fin_state);
							cnt = cnt + 1'b1;
						end
					end
				end
			end
		end

		// status-only result
		if (cnt == '0) begin
			res[0] = sawe_pkg::mk_result(sawe_pkg::SEND_NONE, 1'b0, '0, '0, '0, 1'b0);
			cnt    = sawe_pkg::RES_W'(1);
		end
		nxt     = v;
		res_cnt = cnt;
	end

endmodule

// ===== src/stop_and_wait_endpoint_unit.sv =====
// Stop-and-wait endpoint. Each accepted item is held in an input register,
// its whole effect on the endpoint state is worked out combinationally, and its
// one to three results land in a result register that drives the output
// channel one result per cycle while out_ready is high, with last_result on the
// final one. The item in the input register moves on only when the last result
// of the item before it is taken, so while results drain the unit holds at most
// one further item. Message lengths live in a 16-entry register file written
// by load items. Registers sit on a 4-bit APB port: msg_count at 0x0,
// timeout_ticks at 0x4, ping_interval_ticks at 0x8, missed-ping limit at 0xC.
// Depends on sawe_pkg and sawe_step.
module stop_and_wait_endpoint_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic signed [31:0] rx_seq,
	input  logic signed [31:0] rx_ack,
	input  logic        rx_fin_flag,
	input  logic        rx_ack_flag,
	input  logic        rx_seq_flag,
	input  logic [9:0]  msg_len_bytes,
	input  logic [3:0]  load_slot,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  send_kind,
	output logic        has_content,
	output logic [3:0]  content_slot,
	output logic signed [31:0] tx_seq,
	output logic signed [31:0] tx_ack,
	output logic        tx_fin,
	output logic        peer_up,
	output logic        finished,
	output logic        last_result
);

	sawe_pkg::cfg_t    cfg_q;
	sawe_pkg::state_t  st_q;
	sawe_pkg::state_t  nxt;
	sawe_pkg::item_t   item_s1;
	sawe_pkg::item_t   item_in;
	logic              valid_s1;
	logic              valid_s2;
	sawe_pkg::result_t res_s2 [sawe_pkg::RES_MAX];
	sawe_pkg::result_t res_c [sawe_pkg::RES_MAX];
	logic [sawe_pkg::RES_W-1:0] cnt_s2;
	logic [sawe_pkg::RES_W-1:0] res_cnt;
	logic [sawe_pkg::RES_W-1:0] idx_q;
	logic              peer_s2;
	logic              done_s2;
	logic [sawe_pkg::LEN_W-1:0] len_tbl_q [sawe_pkg::MAX_MSGS];
	logic [sawe_pkg::LEN_W-1:0] rd_len;
	sawe_pkg::tbl_wr_t tbl_wr;
	sawe_pkg::reg_idx_t reg_idx;
	sawe_pkg::result_t cur_res;
	logic              out_last;
	logic              s2_free;
	logic              advance;
	logic              cfg_we;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = sawe_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.msg_count           <= '0;
			cfg_q.timeout_ticks       <= sawe_pkg::TICK_W'(3000);
			cfg_q.ping_interval_ticks <= sawe_pkg::TICK_W'(2000);
			cfg_q.miss_limit          <= sawe_pkg::MISS_W'(9);
		end else if (cfg_we) begin
			case (reg_idx)
				sawe_pkg::REG_MSG_COUNT:     cfg_q.msg_count <= pwdata[sawe_pkg::CNT_W-1:0];
				sawe_pkg::REG_TIMEOUT:       cfg_q.timeout_ticks <= pwdata[sawe_pkg::TICK_W-1:0];
				sawe_pkg::REG_PING_INTERVAL: begin
					cfg_q.ping_interval_ticks <= pwdata[sawe_pkg::TICK_W-1:0];
				end
				sawe_pkg::REG_DOWN_THRESH:   cfg_q.miss_limit <= pwdata[sawe_pkg::MISS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sawe_pkg::REG_MSG_COUNT:     prdata = 32'(cfg_q.msg_count);
			sawe_pkg::REG_TIMEOUT:       prdata = 32'(cfg_q.timeout_ticks);
			sawe_pkg::REG_PING_INTERVAL: prdata = 32'(cfg_q.ping_interval_ticks);
			sawe_pkg::REG_DOWN_THRESH:   prdata = 32'(cfg_q.miss_limit);
			default:                     prdata = '0;
		endcase
	end

	// handshake and stage control
	assign out_last = (idx_q == cnt_s2 - 1'b1);
	assign s2_free  = !valid_s2 || (out_ready && out_last);
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || advance;

	assign item_in.req_type      = req_type;
	assign item_in.rx_seq        = rx_seq;
	assign item_in.rx_ack        = rx_ack;
	assign item_in.rx_fin_flag   = rx_fin_flag;
	assign item_in.rx_ack_flag   = rx_ack_flag;
	assign item_in.rx_seq_flag   = rx_seq_flag;
	assign item_in.msg_len_bytes = msg_len_bytes;
	assign item_in.load_slot     = load_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

	// length table
	assign rd_len = len_tbl_q[st_q.next_slot[sawe_pkg::SLOT_W-1:0]];

	always_ff @(posedge clk) begin
		if (advance && tbl_wr.we) begin
			len_tbl_q[tbl_wr.addr] <= tbl_wr.data;
		end
	end

	sawe_step u_step (
		.st      (st_q),
		.cfg     (cfg_q),
		.item    (item_s1),
		.rd_len  (rd_len),
		.nxt     (nxt),
		.res     (res_c),
		.res_cnt (res_cnt),
		.tbl_wr  (tbl_wr)
	);

	// endpoint state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.next_slot     <= '0;
			st_q.cur_seq       <= sawe_pkg::SEQ_W'(1);
			st_q.cur_ack       <= '1;
			st_q.fin_state     <= 1'b1;
			st_q.clear_to_send <= 1'b1;
			st_q.peer_is_up    <= 1'b0;
			st_q.ping_on       <= 1'b0;
			st_q.drop_regular  <= 1'b1;
			st_q.node_is_down  <= 1'b0;
			st_q.timer_running <= 1'b0;
			st_q.timer_ticks   <= '0;
			st_q.alarm_ticks   <= '0;
			st_q.missed_pings  <= '0;
			st_q.last_rx_fin   <= sawe_pkg::RXF_NONE;
			st_q.done_flag     <= 1'b0;
			st_q.sent_len      <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (valid_s2 && out_ready) begin
			if (out_last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= res_c;
			cnt_s2  <= res_cnt;
			peer_s2 <= nxt.peer_is_up;
			done_s2 <= nxt.done_flag;
		end
	end

	assign cur_res      = res_s2[idx_q];
	assign out_valid    = valid_s2;
	assign send_kind    = cur_res.send_kind;
	assign has_content  = cur_res.has_content;
	assign content_slot = cur_res.content_slot;
	assign tx_seq       = cur_res.tx_seq;
	assign tx_ack       = cur_res.tx_ack;
	assign tx_fin       = cur_res.tx_fin;
	assign peer_up      = peer_s2;
	assign finished     = done_s2;
	assign last_result  = out_last;

endmodule

// ===== dv/stop_and_wait_endpoint_unit_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for stop_and_wait_endpoint_unit: random and directed items,
// APB register phases, results checked against an in-bench model of the endpoint
// depends on sawe_pkg and the endpoint RTL
module stop_and_wait_endpoint_unit_test;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	typedef struct packed {
		sawe_pkg::result_t body;
		logic    up_flag;
		logic    fin_flag;
		logic    tail;
	} frame_t;

	class arq_scoreboard;
		logic [4:0]  cfg_count;
		logic [15:0] cfg_timeout;
		logic [15:0] cfg_interval;
		logic [7:0]  cfg_down_limit;

		logic [4:0]  slot_next;
		logic [31:0] seq_now;
		logic [31:0] ack_now;
		logic        fin_st;
		logic        cts;
		logic        peer;
		logic        ping_en;
		logic        drop_on;
		logic        local_off;
		logic        tmr_on;
		logic [15:0] tmr;
		logic [15:0] alarm;
		logic [7:0]  missed;
		sawe_pkg::rx_fin_t last_fin;
		logic        closed_out;
		logic [9:0]  lengths [sawe_pkg::MAX_MSGS];

		frame_t step_out [$];
		frame_t pending [$];
		int     mismatches;

		function new();
			cfg_count = '0;
			cfg_timeout = 16'd3000;
			cfg_interval = 16'd2000;
			cfg_down_limit = 8'd9;
			slot_next = '0;
			seq_now = 32'd1;
			ack_now = 32'hffff_ffff;
			fin_st = 1'b1;
			cts = 1'b1;
			peer = 1'b0;
			ping_en = 1'b0;
			drop_on = 1'b1;
			local_off = 1'b0;
			tmr_on = 1'b0;
			tmr = '0;
			alarm = '0;
			missed = '0;
			last_fin = sawe_pkg::RXF_NONE;
			closed_out = 1'b0;
			foreach (lengths[i]) lengths[i] = '0;
			mismatches = 0;
		endfunction

		function void set_register(sawe_pkg::reg_idx_t r, logic [31:0] v);
			case (r)
				sawe_pkg::REG_MSG_COUNT:     cfg_count = v[4:0];
				sawe_pkg::REG_TIMEOUT:       cfg_timeout = v[15:0];
				sawe_pkg::REG_PING_INTERVAL: cfg_interval = v[15:0];
				sawe_pkg::REG_DOWN_THRESH:   cfg_down_limit = v[7:0];
				default: ;
			endcase
		endfunction

		function int unsigned msgs_to_send();
			return (cfg_count > sawe_pkg::MAX_MSGS) ? sawe_pkg::MAX_MSGS : cfg_count;
		endfunction

		function logic [31:0] bits_of(logic [4:0] s);
			return {19'b0, lengths[s[3:0]], 3'b000};
		endfunction

		// ack number that would match the message in flight
		function logic [31:0] ack_target();
			if (msgs_to_send() != 0 && slot_next != 0)
				return seq_now + bits_of(slot_next - 5'd1);
			return seq_now;
		endfunction

		function void push_send(sawe_pkg::send_kind_t k, logic has, logic [3:0] slot,
				logic [31:0] s, logic [31:0] a, logic f);
			frame_t fr;
			fr = '0;
			fr.body.send_kind = k;
			fr.body.has_content = has;
			fr.body.content_slot = has ? slot : 4'd0;
			fr.body.tx_seq = s;
			fr.body.tx_ack = a;
			fr.body.tx_fin = f;
			if (step_out.size() < sawe_pkg::RES_MAX)
				step_out.push_back(fr);
		endfunction

		function void acked();
			tmr_on = 1'b0;
			cts = 1'b1;
			ack_now = 32'hffff_ffff;
		endfunction

		function void take_item(sawe_pkg::item_t it);
			int unsigned n;
			logic closed;
			step_out.delete();
			if (!closed_out) begin
				n = msgs_to_send();
				if (n != 0)
					ping_en = 1'b1;
				if (n != 0 && slot_next < n)
					fin_st = 1'b0;
				case (it.req_type)
					sawe_pkg::REQ_LOAD_LEN: lengths[it.load_slot] = it.msg_len_bytes;
					sawe_pkg::REQ_TOGGLE_DROP: drop_on = !drop_on;
					sawe_pkg::REQ_TOGGLE_DOWN: begin
						local_off = !local_off;
						if (local_off)
							tmr_on = 1'b0;
					end
					sawe_pkg::REQ_TICK: begin
						if (tmr_on && tmr != 16'hffff)
							tmr++;
						if (alarm != 16'hffff)
							alarm++;
						if (alarm >= cfg_interval) begin
							alarm = '0;
							if (missed != 8'hff)
								missed++;
							if (ping_en && !local_off)
								push_send(sawe_pkg::SEND_PING, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0);
						end
					end
					default: ;
				endcase

				if (peer && !local_off) begin
					if (cts && slot_next < n) begin
						if (slot_next == 0)
							seq_now = 32'd1;
						else
							seq_now += bits_of(slot_next - 5'd1);
						if (slot_next == n - 1)
							fin_st = 1'b1;
						push_send(sawe_pkg::SEND_REGULAR, 1'b1, 4'(slot_next), seq_now, ack_now,
							fin_st);
						tmr_on = 1'b1;
						tmr = '0;
						slot_next++;
						cts = 1'b0;
					end
					if (missed > cfg_down_limit &&
							(fin_st != 1'b1 || last_fin == sawe_pkg::RXF_NO_FIN))
						peer = 1'b0;
					if (tmr_on && tmr > cfg_timeout) begin
						if (slot_next <= n && slot_next != 0)
							push_send(sawe_pkg::SEND_REGULAR, 1'b1, 4'(slot_next - 5'd1), seq_now,
								ack_now, fin_st);
						else
							push_send(sawe_pkg::SEND_REGULAR, 1'b0, 4'd0, seq_now, ack_now, fin_st);
						tmr_on = 1'b1;
						tmr = '0;
					end
				end

				if (it.req_type == sawe_pkg::REQ_RX_PING ||
						it.req_type == sawe_pkg::REQ_RX_REGULAR) begin
					last_fin = (it.req_type == sawe_pkg::REQ_RX_REGULAR && it.rx_fin_flag) ?
						sawe_pkg::RXF_FIN : sawe_pkg::RXF_NO_FIN;
					if (!local_off && it.req_type == sawe_pkg::REQ_RX_PING) begin
						missed = '0;
						peer = 1'b1;
						if (!ping_en) begin
							ping_en = 1'b1;
							fin_st = 1'b0;
						end
					end else if (!local_off && !drop_on) begin
						closed = 1'b0;
						if (it.rx_fin_flag) begin
							ack_now = it.rx_seq + 32'd1;
							if (n == 0 || slot_next >= n)
								fin_st = 1'b1;
							push_send(sawe_pkg::SEND_REGULAR, 1'b0, 4'd0, it.rx_ack, ack_now, fin_st);
							tmr_on = 1'b1;
							tmr = '0;
						end
						if (it.rx_ack_flag) begin
							if (fin_st != 1'b1 && n == 0) begin
								if (it.rx_ack == seq_now)
									acked();
							end else if (n != 0 && slot_next != 0
									&& it.rx_ack == seq_now + bits_of(slot_next - 5'd1)) begin
								acked();
							end else if (fin_st == 1'b1 && it.rx_ack == seq_now + 32'd1) begin
								seq_now = seq_now + 32'd1;
								ack_now = it.rx_seq + 32'd1;
								push_send(sawe_pkg::SEND_REGULAR, 1'b0, 4'd0, seq_now, ack_now,
									fin_st);
								ping_en = 1'b0;
								closed_out = 1'b1;
								closed = 1'b1;
							end
						end
						if (!closed && fin_st != 1'b1 && it.rx_seq_flag) begin
							ack_now = it.rx_seq + {19'b0, it.msg_len_bytes, 3'b000};
							if (n <= slot_next)
								push_send(sawe_pkg::SEND_REGULAR, 1'b0, 4'd0, seq_now, ack_now,
									fin_st);
						end
					end
				end
			end

			if (step_out.size() == 0)
				push_send(sawe_pkg::SEND_NONE, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0);
			foreach (step_out[k]) begin
				step_out[k].up_flag = peer;
				step_out[k].fin_flag = closed_out;
				step_out[k].tail = (k == step_out.size() - 1);
				pending.push_back(step_out[k]);
			end
		endfunction

		function void compare(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
				mismatches++;
			end
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: expected none, actual kind %0d seq %h ack %h",
					$time, got.body.send_kind, got.body.tx_seq, got.body.tx_ack);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			compare("send_kind", want.body.send_kind, got.body.send_kind);
			compare("has_content", want.body.has_content, got.body.has_content);
			compare("content_slot", want.body.content_slot, got.body.content_slot);
			compare("tx_seq", want.body.tx_seq, got.body.tx_seq);
			compare("tx_ack", want.body.tx_ack, got.body.tx_ack);
			compare("tx_fin", want.body.tx_fin, got.body.tx_fin);
			compare("peer_up", want.up_flag, got.up_flag);
			compare("finished", want.fin_flag, got.fin_flag);
			compare("last_result", want.tail, got.tail);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         req_type = '0;
	logic signed [31:0] rx_seq = '0;
	logic signed [31:0] rx_ack = '0;
	logic               rx_fin_flag = 1'b0;
	logic               rx_ack_flag = 1'b0;
	logic               rx_seq_flag = 1'b0;
	logic [9:0]         msg_len_bytes = '0;
	logic [3:0]         load_slot = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         send_kind;
	logic               has_content;
	logic [3:0]         content_slot;
	logic signed [31:0] tx_seq;
	logic signed [31:0] tx_ack;
	logic               tx_fin;
	logic               peer_up;
	logic               finished;
	logic               last_result;

	arq_scoreboard sb;
	int burst_left = 0;
	int ready_run = 0;
	int stall_run = 0;

	stop_and_wait_endpoint_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
			out_ready <= 1'b0;
		end else if (ready_run > 0) begin
			ready_run--;
			out_ready <= 1'b1;
		end else begin
			stall_run = $urandom_range(0, 5);
			ready_run = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
			out_ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		frame_t got;
		if (arst_n && out_valid && out_ready) begin
			got.body.send_kind = sawe_pkg::send_kind_t'(send_kind);
			got.body.has_content = has_content;
			got.body.content_slot = content_slot;
			got.body.tx_seq = tx_seq;
			got.body.tx_ack = tx_ack;
			got.body.tx_fin = tx_fin;
			got.up_flag = peer_up;
			got.fin_flag = finished;
			got.tail = last_result;
			sb.check_frame(got);
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic sawe_pkg::item_t mk_event(logic [2:0] kind, logic [31:0] s,
			logic [31:0] a, logic f_fin, logic f_ack, logic f_seq, logic [9:0] len,
			logic [3:0] slot);
		sawe_pkg::item_t it;
		it.req_type = kind;
		it.rx_seq = s;
		it.rx_ack = a;
		it.rx_fin_flag = f_fin;
		it.rx_ack_flag = f_ack;
		it.rx_seq_flag = f_seq;
		it.msg_len_bytes = len;
		it.load_slot = slot;
		return it;
	endfunction

	function automatic sawe_pkg::item_t pick_event();
		sawe_pkg::item_t it;
		int unsigned roll;
		it = mk_event(sawe_pkg::REQ_TICK, pick_word(), pick_word(), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
			4'($urandom_range(0, 15)));
		roll = $urandom_range(0, 99);
		if (sb.local_off && roll < 30) begin
			it.req_type = sawe_pkg::REQ_TOGGLE_DOWN;
		end else if (sb.drop_on && roll < 60) begin
			it.req_type = sawe_pkg::REQ_TOGGLE_DROP;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 36) begin
				it.req_type = sawe_pkg::REQ_TICK;
			end else if (roll < 46) begin
				it.req_type = sawe_pkg::REQ_RX_PING;
			end else if (roll < 80) begin
				it.req_type = sawe_pkg::REQ_RX_REGULAR;
				if (roll < 63) begin
					it.rx_ack = sb.ack_target();
					it.rx_ack_flag = 1'b1;
					it.rx_fin_flag = ($urandom_range(0, 3) == 0);
				end
			end else if (roll < 88) begin
				it.req_type = sawe_pkg::REQ_LOAD_LEN;
			end else if (roll < 92) begin
				it.req_type = sawe_pkg::REQ_TOGGLE_DROP;
			end else if (roll < 96) begin
				it.req_type = sawe_pkg::REQ_TOGGLE_DOWN;
			end else begin
				it.req_type = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
			end
		end
		return it;
	endfunction

	task automatic push_item(input sawe_pkg::item_t it);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
		end
		req_type <= it.req_type;
		rx_seq <= it.rx_seq;
		rx_ack <= it.rx_ack;
		rx_fin_flag <= it.rx_fin_flag;
		rx_ack_flag <= it.rx_ack_flag;
		rx_seq_flag <= it.rx_seq_flag;
		msg_len_bytes <= it.msg_len_bytes;
		load_slot <= it.load_slot;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.take_item(it);
		burst_left--;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input sawe_pkg::reg_idx_t r, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(r, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] cnt, input logic [31:0] tmo,
			input logic [31:0] piv, input logic [31:0] dth, input int items);
		settle();
		apb_write(sawe_pkg::REG_MSG_COUNT, cnt);
		apb_write(sawe_pkg::REG_TIMEOUT, tmo);
		apb_write(sawe_pkg::REG_PING_INTERVAL, piv);
		apb_write(sawe_pkg::REG_DOWN_THRESH, dth);
		repeat (items) push_item(pick_event());
	endtask

	initial begin
		int tries;
		sb = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// every slot gets a length before any message can go out
		for (int i = 0; i < sawe_pkg::MAX_MSGS; i++)
			push_item(mk_event(sawe_pkg::REQ_LOAD_LEN, $urandom, $urandom, 1'b0, 1'b0, 1'b0,
				(i == 0) ? 10'd0 : (i == sawe_pkg::MAX_MSGS - 1) ? 10'h3ff :
				10'($urandom_range(1, 1022)), 4'(i)));
		push_item(mk_event(sawe_pkg::REQ_TICK, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 10'd0, 4'd0));
		push_item(mk_event(REQ_SPARE_LO, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1,
			10'h3ff, 4'hf));
		push_item(mk_event(REQ_SPARE_HI, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 10'd0, 4'd0));
		// regular while dropping
		push_item(mk_event(sawe_pkg::REQ_RX_REGULAR, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1,
			1'b1, 10'h3ff, 4'hf));
		push_item(mk_event(sawe_pkg::REQ_TOGGLE_DOWN, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 10'd0,
			4'd0));
		push_item(mk_event(sawe_pkg::REQ_RX_PING, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 10'd0, 4'd0));
		push_item(mk_event(sawe_pkg::REQ_RX_REGULAR, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0,
			1'b1, 10'd5, 4'd0));
		push_item(mk_event(sawe_pkg::REQ_TOGGLE_DOWN, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 10'd0,
			4'd0));
		push_item(mk_event(sawe_pkg::REQ_TOGGLE_DROP, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 10'd0,
			4'd0));
		push_item(mk_event(sawe_pkg::REQ_RX_PING, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 10'd0, 4'd0));
		push_item(mk_event(sawe_pkg::REQ_RX_REGULAR, 32'hffff_ffff, 32'h8000_0000, 1'b1, 1'b0,
			1'b1, 10'h3ff, 4'd0));
		push_item(mk_event(sawe_pkg::REQ_RX_REGULAR, 32'h7fff_ffff, sb.seq_now, 1'b0, 1'b1,
			1'b1, 10'h3ff, 4'd0));

		run_phase(32'd1, 32'd5, 32'd3, 32'd2, 60);
		run_phase(32'd4, 32'd1, 32'd1, 32'd0, 60);
		run_phase(32'd0, 32'd0, 32'd0, 32'd255, 60);
		run_phase(32'd9, 32'd65535, 32'd2, 32'd4, 60);
		run_phase(32'd16, 32'd3, 32'd65535, 32'd1, 60);
		run_phase(32'd31, 32'd8, 32'd4, 32'd3, 60);
		run_phase($urandom_range(0, 31), $urandom_range(1, 24), $urandom_range(0, 9),
			$urandom_range(0, 8), 60);
		run_phase($urandom, $urandom, $urandom_range(0, 12), $urandom, 60);

		// closing handshake, then items that must be ignored
		run_phase(32'd0, 32'd10, 32'd6, 32'd255, 0);
		tries = 0;
		while (!sb.closed_out && tries < 12) begin
			if (sb.local_off)
				push_item(mk_event(sawe_pkg::REQ_TOGGLE_DOWN, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0,
					10'd0, 4'd0));
			else if (sb.drop_on)
				push_item(mk_event(sawe_pkg::REQ_TOGGLE_DROP, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0,
					10'd0, 4'd0));
			else
				push_item(mk_event(sawe_pkg::REQ_RX_REGULAR, pick_word(), sb.seq_now + 32'd1,
					1'b1, 1'b1, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
					4'($urandom_range(0, 15))));
			tries++;
		end
		repeat (4) push_item(pick_event());

		settle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== sim.f =====
src/sawe_pkg.sv
src/sawe_step.sv
src/stop_and_wait_endpoint_unit.sv
dv/stop_and_wait_endpoint_unit_test.sv
